// File: hdl/ebfp_pkg.sv
// Package for the eased backlight fade PWM unit.
// Holds the item structs, command codes, controller states and the duty curve table.
// No dependencies.
package ebfp_pkg;

  localparam int unsigned DUTY_BITS     = 8;
  localparam int unsigned LEVEL_W       = 7;
  localparam int unsigned MAX_LEVEL     = 100;
  localparam int unsigned LEVEL_SQ_FULL = 10000;
  localparam int unsigned LUT_DEPTH     = 1 << LEVEL_W;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_FADE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  level;
    logic [15:0] duration_ms;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic [LEVEL_W-1:0]   level_now;
    logic                 busy_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_EASE,
    ST_MIX,
    ST_RESULT
  } state_t;

  typedef logic [LUT_DEPTH-1:0][DUTY_BITS-1:0] duty_lut_t;

  // Duty for each level: level^2 * 255 / 10000, truncated. Built at elaboration.
  function automatic duty_lut_t build_duty_lut();
    duty_lut_t   t;
    int unsigned v;
    for (int unsigned i = 0; i < LUT_DEPTH; i++) begin
      v    = (i * i * ((1 << DUTY_BITS) - 1)) / LEVEL_SQ_FULL;
      t[i] = DUTY_BITS'(v);
    end
    return t;
  endfunction

  localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

// File: hdl/eased_backlight_fade_pwm_unit.sv
// Top level of the eased backlight fade PWM unit: command handling, bit-serial
// progress divider, smoothstep ease and duty lookup.
// Depends on ebfp_pkg.
//
// Usage: each transfer on the input channel (in_valid/in_ready, payload in_data)
// is a millisecond tick, an immediate level set, the start of a fade, or the unused code 3 (no effect). Every
// item gives exactly one result on the output channel (out_valid/out_ready,
// payload out_data) holding the PWM duty, the current level and the busy flag.
// Flow: a set, a fade start, an idle tick or the last tick of a fade goes from
// the transfer through the result state into the output register. A tick inside
// a fade first runs the restoring divider, which produces one quotient bit of
// elapsed/duration per cycle, then the square, ease and mix multiplies, each in
// its own registered state, before the result state.
// One item is processed at a time; in_ready is high whenever the controller is
// idle, also while a finished result waits in the output register.
// When the receiver stalls, the result is held in the output register and the
// next item stops in its result stage until the register frees up.
// Reset clears the level, the fade state and the output valid flag.
module eased_backlight_fade_pwm_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ebfp_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ebfp_pkg::out_item_t out_data
);

  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(F);
  localparam int unsigned LW    = ebfp_pkg::LEVEL_W;
  localparam int unsigned NUM_W = F + LW + 1;
  localparam logic [F+1:0] THREE_ONE = (F + 2)'(3) << F;
  localparam logic [LW-1:0] LEVEL_MAX = LW'(ebfp_pkg::MAX_LEVEL);

  ebfp_pkg::state_t state, state_next;

  logic [LW-1:0]  current_level, current_level_next;
  logic [LW-1:0]  start_level, start_level_next;
  logic [LW-1:0]  target_level, target_level_next;
  logic [15:0]    elapsed_ms, elapsed_ms_next;
  logic [15:0]    fade_length_ms, fade_length_ms_next;
  logic [16:0]    rem, rem_next;
  logic [F-1:0]   quo, quo_next;
  logic [F-1:0]   k2, k2_next;
  logic [F-1:0]   ease, ease_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic           in_fire;
  logic           load_out;
  logic [LW-1:0]  lvl_sat;
  logic [15:0]    elapsed_inc;
  logic           tick_runs;
  logic [16:0]    rem_shift;
  logic           rem_ge;
  logic [2*F-1:0] sq_prod;
  logic [2*F+1:0] ease_prod;
  logic [F+1:0]   ease_factor;
  logic           mix_up;
  logic [LW-1:0]  mix_diff;
  logic [LW+F-1:0] mix_prod;
  logic [NUM_W-1:0] mix_base;
  logic [NUM_W-1:0] mix_num;
  logic [LW:0]    mix_level;
  logic [LW-1:0]  mix_sat;

  assign in_fire = in_valid && in_ready;
  assign lvl_sat = (in_data.level > 8'(ebfp_pkg::MAX_LEVEL)) ? LEVEL_MAX : in_data.level[LW-1:0];
  assign elapsed_inc = elapsed_ms + 16'd1;
  assign tick_runs = (in_data.cmd == ebfp_pkg::CMD_TICK) && (fade_length_ms != 16'd0)
                     && (elapsed_inc < fade_length_ms);

  // Restoring divider step: one quotient bit per cycle.
  assign rem_shift = {rem[15:0], 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, fade_length_ms};

  assign sq_prod     = quo * quo;
  assign ease_factor = THREE_ONE - {1'b0, quo, 1'b0};
  assign ease_prod   = k2 * ease_factor;

  assign mix_up    = target_level >= start_level;
  assign mix_diff  = mix_up ? (target_level - start_level) : (start_level - target_level);
  assign mix_prod  = mix_diff * ease;
  assign mix_base  = NUM_W'(start_level) << F;
  assign mix_num   = mix_up ? (mix_base + NUM_W'(mix_prod)) : (mix_base - NUM_W'(mix_prod));
  assign mix_level = mix_num[NUM_W-1:F];
  assign mix_sat   = (mix_level > (LW + 1)'(ebfp_pkg::MAX_LEVEL)) ? LEVEL_MAX : mix_level[LW-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ebfp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = tick_runs ? ebfp_pkg::ST_DIV : ebfp_pkg::ST_RESULT;
        end
      end
      ebfp_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = ebfp_pkg::ST_SQ;
        end
      end
      ebfp_pkg::ST_SQ:   state_next = ebfp_pkg::ST_EASE;
      ebfp_pkg::ST_EASE: state_next = ebfp_pkg::ST_MIX;
      ebfp_pkg::ST_MIX:  state_next = ebfp_pkg::ST_RESULT;
      ebfp_pkg::ST_RESULT: begin
        if (load_out) begin
          state_next = ebfp_pkg::ST_IDLE;
        end
      end
      default: state_next = ebfp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ebfp_pkg::ST_IDLE:   in_ready = 1'b1;
      ebfp_pkg::ST_RESULT: load_out = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    current_level_next  = current_level;
    start_level_next    = start_level;
    target_level_next   = target_level;
    elapsed_ms_next     = elapsed_ms;
    fade_length_ms_next = fade_length_ms;
    rem_next            = rem;
    quo_next            = quo;
    k2_next             = k2;
    ease_next           = ease;
    cnt_next            = cnt;
    case (state)
      ebfp_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.cmd)
            ebfp_pkg::CMD_TICK: begin
              if (fade_length_ms != 16'd0) begin
                elapsed_ms_next = elapsed_inc;
                if (tick_runs) begin
                  rem_next = {1'b0, elapsed_inc};
                  cnt_next = CNT_W'(F - 1);
                end else begin
                  fade_length_ms_next = 16'd0;
                  current_level_next  = target_level;
                end
              end
            end
            ebfp_pkg::CMD_SET: begin
              fade_length_ms_next = 16'd0;
              current_level_next  = lvl_sat;
            end
            ebfp_pkg::CMD_FADE: begin
              if (in_data.duration_ms == 16'd0) begin
                fade_length_ms_next = 16'd0;
                current_level_next  = lvl_sat;
              end else begin
                start_level_next    = current_level;
                target_level_next   = lvl_sat;
                elapsed_ms_next     = 16'd0;
                fade_length_ms_next = in_data.duration_ms;
              end
            end
            default: begin
              current_level_next = current_level;
            end
          endcase
        end
      end
      ebfp_pkg::ST_DIV: begin
        rem_next = rem_ge ? (rem_shift - {1'b0, fade_length_ms}) : rem_shift;
        quo_next = {quo[F-2:0], rem_ge};
        cnt_next = cnt - CNT_W'(1);
      end
      ebfp_pkg::ST_SQ:   k2_next = sq_prod[2*F-1:F];
      ebfp_pkg::ST_EASE: ease_next = ease_prod[2*F-1:F];
      ebfp_pkg::ST_MIX:  current_level_next = mix_sat;
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ebfp_pkg::ST_IDLE;
      current_level  <= '0;
      start_level    <= '0;
      target_level   <= '0;
      elapsed_ms     <= '0;
      fade_length_ms <= '0;
      cnt            <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      current_level  <= current_level_next;
      start_level    <= start_level_next;
      target_level   <= target_level_next;
      elapsed_ms     <= elapsed_ms_next;
      fade_length_ms <= fade_length_ms_next;
      cnt            <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem  <= rem_next;
    quo  <= quo_next;
    k2   <= k2_next;
    ease <= ease_next;
    if (load_out) begin
      out_data.duty      <= ebfp_pkg::DUTY_LUT[current_level];
      out_data.level_now <= current_level;
      out_data.busy_res  <= fade_length_ms != 16'd0;
    end
  end

  // The level registers never leave the percent range.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (current_level <= LEVEL_MAX) && (start_level <= LEVEL_MAX) && (target_level <= LEVEL_MAX))
    else $error("level register above full scale");

  // The divider only runs on an active fade, with the partial remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ebfp_pkg::ST_DIV) |-> (fade_length_ms != 16'd0) && (rem < {1'b0, fade_length_ms}))
    else $error("divider remainder out of range");

  // An active fade always has elapsed time short of its length.
  a_fade_progress: assert property (@(posedge clk) disable iff (rst)
    (fade_length_ms != 16'd0) |-> (elapsed_ms < fade_length_ms))
    else $error("fade outlived its duration");

  // Every accepted item leaves the idle state on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != ebfp_pkg::ST_IDLE))
    else $error("accepted item was dropped");

endmodule

// File: verif/eased_backlight_fade_pwm_unit_check.sv
// Checker for the eased backlight fade PWM unit: watches both channels, predicts
// every result from its own copy of the fade state and compares field by field.
// Depends on ebfp_pkg.
module eased_backlight_fade_pwm_unit_check #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ebfp_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ebfp_pkg::out_item_t out_data,
  output int unsigned         in_xfers,
  output int unsigned         out_xfers,
  output int unsigned         pending,
  output int unsigned         fades_done,
  output int unsigned         mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] Q_ONE = 64'd1 << FRACTION_BITS;

  logic [ebfp_pkg::LEVEL_W-1:0] lvl_now;
  logic [ebfp_pkg::LEVEL_W-1:0] fade_from;
  logic [ebfp_pkg::LEVEL_W-1:0] fade_to;
  logic [15:0]                  ms_elapsed;
  logic [15:0]                  ms_length;
  ebfp_pkg::out_item_t          brightness_q[$];

  function automatic logic [ebfp_pkg::LEVEL_W-1:0] clamp_percent(logic [63:0] v);
    return (v > ebfp_pkg::MAX_LEVEL) ? ebfp_pkg::LEVEL_W'(ebfp_pkg::MAX_LEVEL)
                                     : ebfp_pkg::LEVEL_W'(v);
  endfunction

  // Applies one command to the fade state and returns the reading it leaves.
  function automatic ebfp_pkg::out_item_t advance_backlight(ebfp_pkg::in_item_t it);
    logic [63:0] k;
    logic [63:0] k2;
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] lvl64;
    ebfp_pkg::out_item_t r;
    case (it.cmd)
      ebfp_pkg::CMD_TICK: begin
        if (ms_length != 16'd0) begin
          ms_elapsed = ms_elapsed + 16'd1;
          if (ms_elapsed >= ms_length) begin
            ms_length = 16'd0;
            lvl_now   = fade_to;
            fades_done++;
          end else begin
            k   = (64'(ms_elapsed) << FRACTION_BITS) / 64'(ms_length);
            k2  = (k * k) >> FRACTION_BITS;
            s   = (k2 * (3 * Q_ONE - 2 * k)) >> FRACTION_BITS;
            num = 64'(fade_from) << FRACTION_BITS;
            if (fade_to >= fade_from) begin
              num = num + 64'(fade_to - fade_from) * s;
            end else begin
              num = num - 64'(fade_from - fade_to) * s;
            end
            lvl_now = clamp_percent(num >> FRACTION_BITS);
          end
        end
      end
      ebfp_pkg::CMD_SET: begin
        ms_length = 16'd0;
        lvl_now   = clamp_percent(64'(it.level));
      end
      ebfp_pkg::CMD_FADE: begin
        if (it.duration_ms == 16'd0) begin
          ms_length = 16'd0;
          lvl_now   = clamp_percent(64'(it.level));
        end else begin
          fade_from  = lvl_now;
          fade_to    = clamp_percent(64'(it.level));
          ms_elapsed = 16'd0;
          ms_length  = it.duration_ms;
        end
      end
      default: ;
    endcase
    lvl64       = 64'(lvl_now);
    r.duty      = ebfp_pkg::DUTY_BITS'((lvl64 * lvl64 * ((64'd1 << ebfp_pkg::DUTY_BITS) - 1))
                                       / ebfp_pkg::LEVEL_SQ_FULL);
    r.level_now = lvl_now;
    r.busy_res  = (ms_length != 16'd0);
    return r;
  endfunction

  always @(posedge clk) begin
    ebfp_pkg::out_item_t want;
    if (rst) begin
      lvl_now    = '0;
      fade_from  = '0;
      fade_to    = '0;
      ms_elapsed = '0;
      ms_length  = '0;
      brightness_q.delete();
      in_xfers   = 0;
      out_xfers  = 0;
      fades_done = 0;
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) begin
        brightness_q.push_back(advance_backlight(in_data));
        in_xfers++;
      end
      if (out_valid && out_ready) begin
        out_xfers++;
        if (brightness_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing expected: duty %0d level %0d busy %0b",
                     $realtime, out_data.duty, out_data.level_now, out_data.busy_res);
          end
          mismatches++;
        end else begin
          want = brightness_q.pop_front();
          if (out_data.duty !== want.duty || out_data.level_now !== want.level_now ||
              out_data.busy_res !== want.busy_res) begin
            if (mismatches < 10) begin
              $display("%0t: result %0d: expected duty %0d level %0d busy %0b, got %0d %0d %0b",
                       $realtime, out_xfers, want.duty, want.level_now, want.busy_res,
                       out_data.duty, out_data.level_now, out_data.busy_res);
            end
            mismatches++;
          end
        end
      end
    end
    pending = brightness_q.size();
  end

endmodule

// File: verif/eased_backlight_fade_pwm_unit_test.sv
// Top of the eased backlight fade PWM unit testbench: clock, reset, stimulus and
// verdict. Depends on ebfp_pkg, the unit itself and eased_backlight_fade_pwm_unit_check.
module eased_backlight_fade_pwm_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1900;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ebfp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ebfp_pkg::out_item_t out_data;

  int unsigned in_xfers;
  int unsigned out_xfers;
  int unsigned pending;
  int unsigned fades_done;
  int unsigned mismatches;

  bit quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned roll;

  eased_backlight_fade_pwm_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  eased_backlight_fade_pwm_unit_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .in_xfers  (in_xfers),
    .out_xfers (out_xfers),
    .pending   (pending),
    .fades_done(fades_done),
    .mismatches(mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("eased_backlight_fade_pwm_unit regression: fail");
    $finish;
  end

  // Receiver: mostly ready, with short stalls and the odd long one.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (quiet || rst) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end
    end
  end

  function automatic ebfp_pkg::in_item_t make_item(logic [1:0] c, logic [7:0] l,
                                                   logic [15:0] d);
    ebfp_pkg::in_item_t it;
    it.cmd         = c;
    it.level       = l;
    it.duration_ms = d;
    return it;
  endfunction

  function automatic ebfp_pkg::in_item_t tick_item();
    return make_item(ebfp_pkg::CMD_TICK, 8'($urandom), 16'($urandom));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(ebfp_pkg::in_item_t it);
    int unsigned gap;
    int unsigned target;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    target = in_xfers + 1;
    in_valid <= 1'b1;
    in_data  <= it;
    @(negedge clk);
    while (in_xfers < target) @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_level();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 100));
  endfunction

  function automatic ebfp_pkg::in_item_t random_item();
    logic [15:0] d;
    d = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    return make_item(2'($urandom_range(0, 3)), 8'($urandom), d);
  endfunction

  initial begin
    int unsigned sent;
    int unsigned ticks;
    int unsigned r;
    logic [15:0] dur;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle tick, saturation, zero-length fade, full fade up, restart,
    // cancel by set, the unused code, the longest fade and a one-tick fade.
    send_item(make_item(ebfp_pkg::CMD_TICK, 8'hff, 16'hffff));
    send_item(make_item(ebfp_pkg::CMD_SET, 8'd0, 16'd0));
    send_item(make_item(ebfp_pkg::CMD_SET, 8'd100, 16'h0000));
    send_item(make_item(ebfp_pkg::CMD_SET, 8'd255, 16'hffff));
    send_item(make_item(ebfp_pkg::CMD_SET, 8'd101, 16'h5a5a));
    send_item(make_item(ebfp_pkg::CMD_FADE, 8'd0, 16'd0));
    send_item(make_item(ebfp_pkg::CMD_FADE, 8'd100, 16'd4));
    repeat (4) send_item(tick_item());
    send_item(tick_item());
    send_item(make_item(ebfp_pkg::CMD_FADE, 8'd255, 16'd0));
    send_item(make_item(ebfp_pkg::CMD_FADE, 8'd3, 16'd6));
    repeat (2) send_item(tick_item());
    send_item(make_item(ebfp_pkg::CMD_FADE, 8'd200, 16'd3));
    send_item(tick_item());
    send_item(make_item(ebfp_pkg::CMD_SET, 8'd37, 16'd9));
    send_item(make_item(CMD_UNUSED, 8'hff, 16'hffff));
    send_item(make_item(ebfp_pkg::CMD_FADE, 8'd80, 16'hffff));
    repeat (2) send_item(tick_item());
    send_item(make_item(CMD_UNUSED, 8'h00, 16'h0000));
    send_item(make_item(ebfp_pkg::CMD_FADE, 8'd0, 16'd1));
    send_item(tick_item());
    wait_for_results();

    // Random: mostly fades followed by runs of ticks, some cut short, plus noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 200 < 2) quiet = ($urandom_range(0, 3) == 0);
      if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 8) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 80) dur = 16'($urandom_range(1, 40));
        else if (r < 95) dur = 16'($urandom_range(41, 600));
        else dur = 16'($urandom);
        send_item(make_item(ebfp_pkg::CMD_FADE, random_level(), dur));
        sent++;
        ticks = (dur <= 40) ? dur + $urandom_range(0, 2) : $urandom_range(1, 60);
        repeat (ticks) begin
          if ($urandom_range(0, 99) < 2) send_item(random_item());
          else send_item(tick_item());
          sent++;
        end
      end else begin
        send_item(random_item());
        sent++;
      end
    end

    wait_for_results();
    repeat (30) @(negedge clk);
    $display("Run covered %0d commands and %0d readings; %0d fades reached their target.",
             in_xfers, out_xfers, fades_done);
    if (mismatches == 0 && pending == 0) begin
      $display("eased_backlight_fade_pwm_unit regression: pass");
    end else begin
      $display("eased_backlight_fade_pwm_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ebfp_pkg.sv
hdl/eased_backlight_fade_pwm_unit.sv
verif/eased_backlight_fade_pwm_unit_check.sv
verif/eased_backlight_fade_pwm_unit_test.sv
